/* sv/dsfc_pkg.sv */
package dsfc_pkg;

  localparam int unsigned CmdWords = 16;
  localparam int unsigned IdxW = 4;

  localparam logic [15:0] MeshBit = 16'h0100;
  localparam logic [15:0] ZeroWord = 16'h0000;

  typedef enum logic [2:0] {
    REG_COMMAND_CODE = 3'd0,
    REG_MODE_BASE    = 3'd1,
    REG_MIN_HALF     = 3'd2,
    REG_SKEW_PEAK    = 3'd3,
    REG_SKEW_DIV     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        action;
    logic [18:0] cmd_base;
    logic [10:0] center_x;
    logic [10:0] center_y;
    logic [10:0] sprite_width;
    logic [7:0]  sprite_height;
    logic [10:0] step_now;
    logic [9:0]  frames;
    logic [18:0] tex_front;
    logic [18:0] tex_back;
    logic [6:0]  color_bank;
    logic        mesh;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [18:0] write_offset;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] command_code;
    logic [15:0] mode_base;
    logic [7:0]  min_half_span;
    logic [7:0]  skew_peak;
    logic [7:0]  skew_divisor;
  } cfg_t;

  // classified job handed from the front to the back
  typedef struct packed {
    logic        reject;
    logic [18:0] cmd_base;
    logic [15:0] mode;
    logic [15:0] colour;
    logic [15:0] tex;
    logic [15:0] size;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] hw;
    logic [15:0] hl;
    logic [15:0] hr;
  } job_t;

endpackage

/* sv/dsfc_if.sv */
interface dsfc_req_if;
  import dsfc_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dsfc_res_if;
  import dsfc_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/dsfc_div.sv */
// restoring unsigned divider, one quotient bit a cycle
module dsfc_div
  import dsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [9:0]  den_i,
  output logic        done_o,
  output logic [23:0] quo_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [23:0] quo_q, quo_d;
  logic [10:0] rem_q, rem_d;
  logic [9:0]  den_q, den_d;
  logic [10:0] trial;
  logic        done_q, done_d;

  assign trial = {rem_q[9:0], quo_q[23]};

  always_comb begin
    busy_d = busy_q;
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = 5'd0;
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[22:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[22:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd23) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

/* sv/dsfc_front.sv */
// classifies a request and works out the quad geometry
module dsfc_front
  import dsfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  dsfc_req_if.sink     req,
  output logic         job_valid_o,
  output job_t         job_o,
  input  logic         job_ready_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_HW, S_SKEW, S_EDGE, S_OUT
  } state_e;

  state_e      state_q;
  req_t        r_q;
  logic [9:0]  fr_q;
  logic [10:0] s_q;
  logic [9:0]  q_q;
  logic [10:0] fold_q;
  logic [15:0] hw_q;
  logic        skneg_q;
  logic [15:0] skew_q;
  logic [15:0] hl_q, hr_q;
  logic        tex_back_q;
  logic        done_q;
  job_t        job_q;

  logic        dv_start;
  logic [23:0] dv_num;
  logic [9:0]  dv_den;
  logic        dv_done;
  logic [23:0] dv_quo;

  dsfc_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo)
  );

  // request decode
  logic [9:0]  fr_c;
  logic signed [11:0] st_c;
  logic [10:0] s_c;
  logic [9:0]  half_c, q_c;
  logic signed [11:0] fold_c;
  logic        reject_c;

  always_comb begin
    fr_c = (req.data.frames == 10'd0) ? 10'd1 : req.data.frames;
    st_c = {req.data.step_now[10], req.data.step_now};
    if (st_c < 0) s_c = '0;
    else if (st_c > $signed({2'b00, fr_c})) s_c = {1'b0, fr_c};
    else s_c = st_c[10:0];
    half_c = {1'b0, fr_c[9:1]};
    q_c = (fr_c[9:2] == 8'd0) ? 10'd1 : {2'b00, fr_c[9:2]};
    fold_c = $signed({1'b0, s_c}) - $signed({2'b00, half_c});
    if (fold_c < 0) fold_c = -fold_c;
    reject_c = (req.data.sprite_width == 11'd0) || (req.data.sprite_height == 8'd0);
  end

  // skew numerator per segment
  logic [10:0] seg_c;
  logic        seg_neg_c;
  always_comb begin
    if (s_q <= {1'b0, q_q}) begin
      seg_c = s_q; seg_neg_c = 1'b0;
    end else if (s_q <= {q_q, 1'b0}) begin
      seg_c = {q_q, 1'b0} - s_q; seg_neg_c = 1'b0;
    end else if ({1'b0, s_q} <= {1'b0, q_q, 1'b0} + {2'b00, q_q}) begin
      seg_c = s_q - {q_q, 1'b0}; seg_neg_c = 1'b1;
    end else begin
      seg_c = {1'b0, fr_q} - s_q; seg_neg_c = 1'b1;
    end
  end

  logic [7:0]  hh_c;
  logic [15:0] sk_c;
  logic [7:0]  div_c;
  assign hh_c = {1'b0, r_q.sprite_height[7:1]};
  assign sk_c = (skew_q > {8'd0, cfg_i.skew_peak}) ? {8'd0, cfg_i.skew_peak} : skew_q;
  assign div_c = (cfg_i.skew_divisor == 8'd0) ? 8'd1 : cfg_i.skew_divisor;

  logic signed [17:0] hl_c, hr_c, dq_c;
  always_comb begin
    dq_c = $signed({2'b00, dv_quo[15:0]});
    if (skneg_q) begin
      hl_c = $signed({10'd0, hh_c}) + dq_c;
      hr_c = $signed({10'd0, hh_c}) - dq_c;
    end else begin
      hl_c = $signed({10'd0, hh_c}) - dq_c;
      hr_c = $signed({10'd0, hh_c}) + dq_c;
    end
  end

  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = fr_q;
    unique case (state_q)
      S_HW: begin
        dv_start = !done_q;
        dv_num = (24'(r_q.sprite_width[10:1]) * 24'(fold_q)) << 1;
        dv_den = fr_q;
      end
      S_SKEW: begin
        dv_start = !done_q;
        dv_num = 24'(cfg_i.skew_peak) * 24'(seg_c);
        dv_den = q_q;
      end
      S_EDGE: begin
        dv_start = !done_q;
        dv_num = 24'(hh_c) * 24'(sk_c[7:0]);
        dv_den = {2'b00, div_c};
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);

  logic [15:0] tex_c;
  logic [18:0] tsel_c;
  always_comb begin
    tsel_c = (r_q.action || !tex_back_q) ? r_q.tex_front : r_q.tex_back;
    tex_c = {tsel_c[18:3]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (req.valid) begin
          r_q <= req.data;
          fr_q <= fr_c;
          s_q <= s_c;
          q_q <= q_c;
          fold_q <= fold_c[10:0];
          tex_back_q <= !(st_c < $signed({2'b00, half_c}));
          done_q <= 1'b0;
          if (reject_c || req.data.action) begin
            hw_q <= {6'd0, req.data.sprite_width[10:1]};
            hl_q <= {9'd0, req.data.sprite_height[7:1]};
            hr_q <= {9'd0, req.data.sprite_height[7:1]};
            state_q <= S_OUT;
          end else begin
            state_q <= S_HW;
          end
        end
        S_HW: begin
          done_q <= 1'b1;
          if (dv_done) begin
            hw_q <= (dv_quo[15:0] < {8'd0, cfg_i.min_half_span}) ?
                    {8'd0, cfg_i.min_half_span} : dv_quo[15:0];
            skneg_q <= seg_neg_c;
            done_q <= 1'b0;
            state_q <= S_SKEW;
          end
        end
        S_SKEW: begin
          done_q <= 1'b1;
          if (dv_done) begin
            skew_q <= dv_quo[15:0];
            done_q <= 1'b0;
            state_q <= S_EDGE;
          end
        end
        S_EDGE: begin
          done_q <= 1'b1;
          if (dv_done) begin
            hl_q <= (hl_c < 18'sd1) ? 16'd1 : hl_c[15:0];
            hr_q <= (hr_c < 18'sd1) ? 16'd1 : hr_c[15:0];
            done_q <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: if (job_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    job_q.reject = (r_q.sprite_width == 11'd0) || (r_q.sprite_height == 8'd0);
    job_q.cmd_base = r_q.cmd_base;
    job_q.mode = cfg_i.mode_base | ((r_q.mesh || r_q.action) ? MeshBit : ZeroWord);
    job_q.colour = {5'd0, r_q.color_bank, 4'd0};
    job_q.tex = tex_c;
    job_q.size = {r_q.sprite_width[10:3], r_q.sprite_height};
    job_q.cx = {{5{r_q.center_x[10]}}, r_q.center_x};
    job_q.cy = {{5{r_q.center_y[10]}}, r_q.center_y};
    job_q.hw = hw_q;
    job_q.hl = hl_q;
    job_q.hr = hr_q;
  end

  assign job_valid_o = (state_q == S_OUT);
  assign job_o = job_q;
endmodule

/* sv/dsfc_back.sv */
// two-entry job queue and word sequencer
module dsfc_back
  import dsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] command_code_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_ready_o,
  dsfc_res_if.source  res
);
  job_t        fifo_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic [IdxW-1:0] idx_q;
  job_t        j;
  logic        push, pop, fire;
  logic [15:0] w;

  assign j = fifo_q[rp_q];
  assign job_ready_o = (cnt_q != 2'd2);
  assign push = job_valid_i && job_ready_o;
  assign fire = res.valid && res.ready;
  assign pop = fire && res.data.last;
  assign res.valid = (cnt_q != 2'd0);

  always_comb begin
    unique case (idx_q)
      4'd0: w = command_code_i;
      4'd2: w = j.mode;
      4'd3: w = j.colour;
      4'd4: w = j.tex;
      4'd5: w = j.size;
      4'd6: w = j.cx - j.hw;
      4'd7: w = j.cy - j.hl;
      4'd8: w = j.cx + j.hw;
      4'd9: w = j.cy - j.hr;
      4'd10: w = j.cx + j.hw;
      4'd11: w = j.cy + j.hr;
      4'd12: w = j.cx - j.hw;
      4'd13: w = j.cy + j.hl;
      default: w = ZeroWord;
    endcase
    res.data.accepted = !j.reject;
    res.data.write_offset = j.cmd_base + {14'd0, idx_q, 1'b0};
    res.data.word_index = idx_q;
    res.data.word_value = j.reject ? ZeroWord : w;
    res.data.last = j.reject || (idx_q == IdxW'(CmdWords - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (fire) idx_q <= pop ? '0 : idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= job_i;
  end
endmodule

/* sv/distorted_sprite_flip_command.sv */
// channel | dir | payload
// req     | in  | req_t, one sprite request per transfer
// res     | out | res_t, sixteen command words or one reject per request
// cfg     | in  | apb write/read of five registers
// a flip request runs three 24-step divisions in the front on one shared
// divider; dissolve and reject skip them. the back sends one word a cycle
// while res.ready is high; a two-job queue lets the front work on the next
// request while words drain. reset is async, active low.
module distorted_sprite_flip_command
  import dsfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dsfc_req_if.sink    req,
  dsfc_res_if.source  res
);
  cfg_t cfg_q;
  logic job_valid, job_ready;
  job_t job;
  reg_idx_e ra;

  assign pready = 1'b1;
  assign ra = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.command_code <= 16'd2;
      cfg_q.mode_base <= 16'd0;
      cfg_q.min_half_span <= 8'd1;
      cfg_q.skew_peak <= 8'd16;
      cfg_q.skew_divisor <= 8'd64;
    end else if (psel && penable && pwrite) begin
      unique case (ra)
        REG_COMMAND_CODE: cfg_q.command_code <= pwdata[15:0];
        REG_MODE_BASE: cfg_q.mode_base <= pwdata[15:0];
        REG_MIN_HALF: cfg_q.min_half_span <= pwdata[7:0];
        REG_SKEW_PEAK: cfg_q.skew_peak <= pwdata[7:0];
        REG_SKEW_DIV: cfg_q.skew_divisor <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      REG_COMMAND_CODE: prdata = {16'd0, cfg_q.command_code};
      REG_MODE_BASE: prdata = {16'd0, cfg_q.mode_base};
      REG_MIN_HALF: prdata = {24'd0, cfg_q.min_half_span};
      REG_SKEW_PEAK: prdata = {24'd0, cfg_q.skew_peak};
      REG_SKEW_DIV: prdata = {24'd0, cfg_q.skew_divisor};
      default: prdata = '0;
    endcase
  end

  dsfc_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .req,
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  dsfc_back u_back (
    .clk_i, .rst_ni, .command_code_i(cfg_q.command_code),
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready), .res
  );
endmodule

/* sv/dsfc_checker.sv */
module dsfc_checker
  import dsfc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result dropped under stall");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready && !res_data.last |=>
    res_valid && res_data.word_index == $past(res_data.word_index) + 4'd1)
    else $error("word sequence broken");
  a_rej: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_data.accepted |-> res_data.last && res_data.word_index == 4'd0)
    else $error("reject not single");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.accepted && res_data.last |-> res_data.word_index == 4'd15)
    else $error("last misplaced");
endmodule

bind distorted_sprite_flip_command dsfc_checker u_chk (
  .clk_i, .rst_ni, .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
